>>> hdl/idq_pkg.sv
package idq_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int DATA_W       = 32;
  localparam int MODE_W       = 3;
  localparam int STATUS_W     = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_BACK  = 3'd0,
    MODE_POP_BACK   = 3'd1,
    MODE_PUSH_FRONT = 3'd2,
    MODE_POP_FRONT  = 3'd3,
    MODE_INSERT     = 3'd4,
    MODE_ERASE      = 3'd5,
    MODE_CLEAR      = 3'd6
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_INDEX = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef struct packed {
    logic ins;
    logic ers;
    logic rd;
  } cell_ctl_t;

endpackage

>>> hdl/idq_cell.sv
module idq_cell #(
  parameter int CNT_W = 7,
  parameter int INDEX = 0
) (
  input  logic                          clk,
  input  idq_pkg::cell_ctl_t            ctl,
  input  logic [CNT_W-1:0]              shift_idx,
  input  logic [CNT_W-1:0]              rd_idx,
  input  logic [idq_pkg::DATA_W-1:0]    word,
  input  logic [idq_pkg::DATA_W-1:0]    left_data,
  input  logic [idq_pkg::DATA_W-1:0]    right_data,
  output logic [idq_pkg::DATA_W-1:0]    data,
  output logic [idq_pkg::DATA_W-1:0]    rd_data
);

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(INDEX);

  logic [idq_pkg::DATA_W-1:0] data_r;
  logic [idq_pkg::DATA_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctl.ins) begin
      if (MY_IDX == shift_idx) begin
        data_nxt = word;
      end else if (MY_IDX > shift_idx) begin
        data_nxt = left_data;
      end
    end else if (ctl.ers) begin
      if (MY_IDX >= shift_idx) begin
        data_nxt = right_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data    = data_r;
  assign rd_data = (ctl.rd && (MY_IDX == rd_idx)) ? data_r : '0;

endmodule

>>> hdl/idq_ctrl.sv
module idq_ctrl #(
  parameter int CAPACITY = idq_pkg::CAPACITY_DEF,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic [idq_pkg::MODE_W-1:0] mode,
  input  logic [CNT_W-1:0]           pos,
  input  logic [CNT_W-1:0]           count,
  output idq_pkg::cell_ctl_t         ctl,
  output logic [CNT_W-1:0]           shift_idx,
  output logic [CNT_W-1:0]           rd_idx,
  output logic [CNT_W-1:0]           count_nxt,
  output idq_pkg::status_t           status
);

  localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY);

  logic full;
  logic empty;

  assign full  = (count >= CAP);
  assign empty = (count == '0);

  always_comb begin
    ctl       = '0;
    shift_idx = '0;
    rd_idx    = '0;
    count_nxt = count;
    status    = idq_pkg::ST_OK;
    unique case (idq_pkg::mode_t'(mode))
      idq_pkg::MODE_PUSH_BACK: begin
        if (full) begin
          status = idq_pkg::ST_FULL;
        end else begin
          ctl.ins   = 1'b1;
          shift_idx = count;
          count_nxt = count + 1'b1;
        end
      end
      idq_pkg::MODE_POP_BACK: begin
        if (empty) begin
          status = idq_pkg::ST_EMPTY;
        end else begin
          ctl.rd    = 1'b1;
          rd_idx    = count - 1'b1;
          count_nxt = count - 1'b1;
        end
      end
      idq_pkg::MODE_PUSH_FRONT: begin
        if (full) begin
          status = idq_pkg::ST_FULL;
        end else begin
          ctl.ins   = 1'b1;
          count_nxt = count + 1'b1;
        end
      end
      idq_pkg::MODE_POP_FRONT: begin
        if (empty) begin
          status = idq_pkg::ST_EMPTY;
        end else begin
          ctl.rd    = 1'b1;
          ctl.ers   = 1'b1;
          count_nxt = count - 1'b1;
        end
      end
      idq_pkg::MODE_INSERT: begin
        if (pos > count) begin
          status = idq_pkg::ST_INDEX;
        end else if (full) begin
          status = idq_pkg::ST_FULL;
        end else begin
          ctl.ins   = 1'b1;
          shift_idx = pos;
          count_nxt = count + 1'b1;
        end
      end
      idq_pkg::MODE_ERASE: begin
        if (empty || (pos > count)) begin
          status = idq_pkg::ST_INDEX;
        end else if (pos < count) begin
          ctl.ers   = 1'b1;
          shift_idx = pos;
          count_nxt = count - 1'b1;
        end
      end
      idq_pkg::MODE_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> hdl/indexed_deque_store.sv
// Channel  Direction  Ports
// in       input      in_valid, in_stall, in_mode, in_value, in_position
// out      output     out_valid, out_stall, out_popped_value, out_occupancy, out_status
//
// One beat per cycle in while in_stall is low, one result beat per input beat, in the cycle after it.
// Every cell updates in the same cycle; the row of cells sets the rate.
// in_stall rises only while a result waits and out_stall is high.
// rst_n clears the count and out_valid; entries and the result registers keep their bits.
module indexed_deque_store #(
  parameter int CAPACITY = idq_pkg::CAPACITY_DEF,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [idq_pkg::MODE_W-1:0]         in_mode,
  input  logic signed [idq_pkg::DATA_W-1:0]  in_value,
  input  logic [CNT_W-1:0]                   in_position,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [idq_pkg::DATA_W-1:0]  out_popped_value,
  output logic [CNT_W-1:0]                   out_occupancy,
  output logic [idq_pkg::STATUS_W-1:0]       out_status
);

  localparam int DW = idq_pkg::DATA_W;

  logic                 accept;
  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     count_nxt;
  logic [CNT_W-1:0]     shift_idx;
  logic [CNT_W-1:0]     rd_idx;
  idq_pkg::cell_ctl_t   dec_ctl;
  idq_pkg::cell_ctl_t   cell_ctl;
  idq_pkg::status_t     status;
  logic [DW-1:0]        cell_data [CAPACITY];
  logic [DW-1:0]        cell_rd   [CAPACITY];
  logic [DW-1:0]        popped;

  logic                 out_valid_r;
  logic                 out_valid_nxt;
  logic [DW-1:0]        popped_r;
  logic [CNT_W-1:0]     occ_r;
  idq_pkg::status_t     status_r;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  idq_ctrl #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .mode      (in_mode),
    .pos       (in_position),
    .count     (count_r),
    .ctl       (dec_ctl),
    .shift_idx (shift_idx),
    .rd_idx    (rd_idx),
    .count_nxt (count_nxt),
    .status    (status)
  );

  assign cell_ctl = accept ? dec_ctl : '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DW-1:0] left_data;
    logic [DW-1:0] right_data;
    if (i == 0) begin : g_first
      assign left_data = '0;
    end else begin : g_mid_l
      assign left_data = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_data = '0;
    end else begin : g_mid_r
      assign right_data = cell_data[i+1];
    end
    idq_cell #(
      .CNT_W (CNT_W),
      .INDEX (i)
    ) u_cell (
      .clk        (clk),
      .ctl        (cell_ctl),
      .shift_idx  (shift_idx),
      .rd_idx     (rd_idx),
      .word       (in_value),
      .left_data  (left_data),
      .right_data (right_data),
      .data       (cell_data[i]),
      .rd_data    (cell_rd[i])
    );
  end

  always_comb begin
    popped = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      popped = popped | cell_rd[i];
    end
  end

  assign out_valid_nxt = accept || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      popped_r <= popped;
      occ_r    <= count_nxt;
      status_r <= status;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_popped_value = popped_r;
  assign out_occupancy    = occ_r;
  assign out_status       = status_r;

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("count above capacity");

  a_accept_result : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted beat without result");

  a_full_status : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == idq_pkg::ST_FULL) |-> (occ_r == CNT_W'(CAPACITY)))
    else $error("full status below capacity");

  a_empty_status : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == idq_pkg::ST_EMPTY) |-> (occ_r == '0 && popped_r == '0))
    else $error("empty status with data");
`endif

endmodule

>>> tb/idq_checker.sv
`timescale 1ns / 100ps

module idq_checker #(
  parameter int CAP   = idq_pkg::CAPACITY_DEF,
  parameter int CNT_W = $clog2(CAP + 1)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic [idq_pkg::MODE_W-1:0]          in_mode,
  input  logic signed [idq_pkg::DATA_W-1:0]   in_value,
  input  logic [CNT_W-1:0]                    in_position,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic signed [idq_pkg::DATA_W-1:0]   out_popped_value,
  input  logic [CNT_W-1:0]                    out_occupancy,
  input  logic [idq_pkg::STATUS_W-1:0]        out_status,
  output int                                  fail_count,
  output int                                  pending,
  output int                                  checked,
  output int                                  peak_fill,
  output logic [3:0]                          status_mask
);

  typedef struct {
    logic signed [idq_pkg::DATA_W-1:0] popped;
    logic [CNT_W-1:0]                  fill;
    idq_pkg::status_t                  status;
  } outcome_t;

  logic signed [idq_pkg::DATA_W-1:0] words [CAP];
  int unsigned                       word_count;
  outcome_t                          predicted_results [$];
  outcome_t                          want;

  task automatic apply_operation(input logic [idq_pkg::MODE_W-1:0] op,
                                 input logic signed [idq_pkg::DATA_W-1:0] word,
                                 input logic [CNT_W-1:0] at);
    outcome_t r;
    int unsigned i;
    r.popped = '0;
    r.status = idq_pkg::ST_OK;
    case (op)
      idq_pkg::MODE_PUSH_BACK: begin
        if (word_count >= CAP) begin
          r.status = idq_pkg::ST_FULL;
        end else begin
          words[word_count] = word;
          word_count++;
        end
      end
      idq_pkg::MODE_POP_BACK: begin
        if (word_count == 0) begin
          r.status = idq_pkg::ST_EMPTY;
        end else begin
          word_count--;
          r.popped = words[word_count];
        end
      end
      idq_pkg::MODE_PUSH_FRONT: begin
        if (word_count >= CAP) begin
          r.status = idq_pkg::ST_FULL;
        end else begin
          for (i = word_count; i > 0; i--) words[i] = words[i-1];
          words[0] = word;
          word_count++;
        end
      end
      idq_pkg::MODE_POP_FRONT: begin
        if (word_count == 0) begin
          r.status = idq_pkg::ST_EMPTY;
        end else begin
          r.popped = words[0];
          for (i = 0; i + 1 < word_count; i++) words[i] = words[i+1];
          word_count--;
        end
      end
      idq_pkg::MODE_INSERT: begin
        if (at > word_count) begin
          r.status = idq_pkg::ST_INDEX;
        end else if (word_count >= CAP) begin
          r.status = idq_pkg::ST_FULL;
        end else begin
          for (i = word_count; i > at; i--) words[i] = words[i-1];
          words[at] = word;
          word_count++;
        end
      end
      idq_pkg::MODE_ERASE: begin
        if (word_count == 0 || at > word_count) begin
          r.status = idq_pkg::ST_INDEX;
        end else if (at < word_count) begin
          for (i = at; i + 1 < word_count; i++) words[i] = words[i+1];
          word_count--;
        end
      end
      idq_pkg::MODE_CLEAR: word_count = 0;
      default: ;
    endcase
    r.fill = word_count[CNT_W-1:0];
    if (word_count > peak_fill) peak_fill = word_count;
    predicted_results.insert(predicted_results.size(), r);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      word_count  = 0;
      fail_count  = 0;
      pending     = 0;
      checked     = 0;
      peak_fill   = 0;
      status_mask = '0;
      predicted_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_results.size() == 0) begin
          $error("result beat with nothing expected: popped_value %0d occupancy %0d status %0d",
                 out_popped_value, out_occupancy, out_status);
          fail_count++;
        end else begin
          want = predicted_results.pop_front();
          checked++;
          status_mask[out_status] = 1'b1;
          if (out_popped_value !== want.popped) begin
            $error("popped_value: expected %0d, actual %0d", want.popped, out_popped_value);
            fail_count++;
          end
          if (out_occupancy !== want.fill) begin
            $error("occupancy: expected %0d, actual %0d", want.fill, out_occupancy);
            fail_count++;
          end
          if (out_status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_status);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) apply_operation(in_mode, in_value, in_position);
      pending = predicted_results.size();
    end
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int CAP   = idq_pkg::CAPACITY_DEF;
  localparam int CNT_W = $clog2(CAP + 1);
  localparam int LIMIT = 200000;
  localparam logic [idq_pkg::MODE_W-1:0] MODE_SPARE = 3'd7;

  logic                                 clk = 1'b0;
  logic                                 rst_n;
  logic                                 in_valid;
  logic                                 in_stall;
  logic [idq_pkg::MODE_W-1:0]           in_mode;
  logic signed [idq_pkg::DATA_W-1:0]    in_value;
  logic [CNT_W-1:0]                     in_position;
  logic                                 out_valid;
  logic                                 out_stall;
  logic signed [idq_pkg::DATA_W-1:0]    out_popped_value;
  logic [CNT_W-1:0]                     out_occupancy;
  logic [idq_pkg::STATUS_W-1:0]         out_status;

  int          fail_count;
  int          pending;
  int          checked;
  int          peak_fill;
  logic [3:0]  status_mask;
  logic        steady = 1'b0;
  int          last_fill = 0;
  int          cycles = 0;

  indexed_deque_store #(.CAPACITY(CAP)) DUT (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_mode, .in_value, .in_position,
    .out_valid, .out_stall, .out_popped_value, .out_occupancy, .out_status
  );

  idq_checker #(.CAP(CAP), .CNT_W(CNT_W)) u_check (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_mode, .in_value, .in_position,
    .out_valid, .out_stall, .out_popped_value, .out_occupancy, .out_status,
    .fail_count, .pending, .checked, .peak_fill, .status_mask
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < 34);
    if (out_valid && !out_stall) last_fill <= out_occupancy;
  end

  task automatic send_beat(input logic [idq_pkg::MODE_W-1:0] op,
                           input logic signed [idq_pkg::DATA_W-1:0] word,
                           input int at);
    logic held;
    while (!steady && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_mode     <= op;
    in_value    <= word;
    in_position <= at[CNT_W-1:0];
    do begin
      @(negedge clk);
      held = in_stall;
      @(posedge clk);
    end while (held);
  endtask

  task automatic random_beat(input int grow_pct);
    int pick;
    int at;
    logic [idq_pkg::MODE_W-1:0] op;
    logic signed [idq_pkg::DATA_W-1:0] word;
    pick = $urandom_range(99);
    if (pick < grow_pct) begin
      case ($urandom_range(2))
        0:       op = idq_pkg::MODE_PUSH_BACK;
        1:       op = idq_pkg::MODE_PUSH_FRONT;
        default: op = idq_pkg::MODE_INSERT;
      endcase
    end else if (pick == 99 && grow_pct <= 50) begin
      op = idq_pkg::MODE_CLEAR;
    end else if (pick == 98) begin
      op = MODE_SPARE;
    end else begin
      case ($urandom_range(2))
        0:       op = idq_pkg::MODE_POP_BACK;
        1:       op = idq_pkg::MODE_POP_FRONT;
        default: op = idq_pkg::MODE_ERASE;
      endcase
    end
    case ($urandom_range(7))
      0:       word = 32'h7FFF_FFFF;
      1:       word = 32'h8000_0000;
      default: word = $urandom;
    endcase
    if ($urandom_range(9) < 6) begin
      at = last_fill + $urandom_range(3) - 2;
      if (at < 0) at = 0;
      if (at > CAP) at = CAP;
    end else begin
      at = $urandom_range(CAP);
    end
    send_beat(op, word, at);
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_mode     <= idq_pkg::MODE_PUSH_BACK;
    in_value    <= '0;
    in_position <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_beat(idq_pkg::MODE_POP_BACK, 0, 0);
    send_beat(idq_pkg::MODE_POP_FRONT, 0, 0);
    send_beat(idq_pkg::MODE_ERASE, 0, 0);
    send_beat(idq_pkg::MODE_INSERT, 32'h1234_5678, 1);
    send_beat(idq_pkg::MODE_INSERT, 32'h7FFF_FFFF, 0);
    send_beat(idq_pkg::MODE_PUSH_BACK, 32'h8000_0000, 0);
    send_beat(idq_pkg::MODE_PUSH_FRONT, -1, 0);
    send_beat(idq_pkg::MODE_INSERT, 32'h5555_5555, 3);
    send_beat(idq_pkg::MODE_INSERT, 32'hAAAA_AAAA, 1);
    send_beat(idq_pkg::MODE_ERASE, 0, 5);
    send_beat(idq_pkg::MODE_ERASE, 0, 6);
    send_beat(idq_pkg::MODE_ERASE, 0, 2);
    send_beat(MODE_SPARE, 32'hFFFF_FFFF, 127);
    send_beat(idq_pkg::MODE_POP_FRONT, 0, 0);
    send_beat(idq_pkg::MODE_POP_BACK, 0, 0);
    send_beat(idq_pkg::MODE_INSERT, 32'h0F0F_0F0F, CAP);
    send_beat(idq_pkg::MODE_ERASE, 0, CAP);
    send_beat(idq_pkg::MODE_CLEAR, 32'hFFFF_FFFF, CAP);
    send_beat(idq_pkg::MODE_POP_BACK, 0, 0);
    send_beat(idq_pkg::MODE_ERASE, 0, 0);
    send_beat(idq_pkg::MODE_PUSH_BACK, 0, 0);
    send_beat(idq_pkg::MODE_PUSH_FRONT, 32'h0000_0001, 0);

    repeat (110) random_beat(92);
    steady <= 1'b1;
    repeat (90) random_beat(50);
    steady <= 1'b0;
    repeat (80) random_beat(15);
    repeat (90) random_beat(92);
    repeat (30) random_beat(50);
    in_valid <= 1'b0;

    do @(negedge clk); while (pending != 0);
    repeat (8) @(posedge clk);

    $display("checked %0d result beats, peak occupancy %0d of %0d", checked, peak_fill, CAP);
    $display("status codes seen (bit per code, 3..0): %b", status_mask);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
